// ===== rtl/set_assoc_cache_tag_replacement_assert.svh =====
// Assertion macros used by the checker module.
`ifndef SET_ASSOC_CACHE_TAG_REPLACEMENT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_REPLACEMENT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SACT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define SACT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sact_pkg.sv =====
`default_nettype none
package sact_pkg;
   localparam int NumSets    = 64;
   localparam int Ways       = 4;
   localparam int BlockBytes = 64;
   localparam int OffW  = $clog2(BlockBytes);
   localparam int SetW  = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int SetB  = $clog2(NumSets);
   localparam int TagW  = 32 - OffW - SetB;
   localparam int WayW  = (Ways > 1) ? $clog2(Ways) : 1;
   // One memory word holds a whole set: per way tag, insert, use stamp, count.
   localparam int EntW  = TagW + 32 + 32 + 16;
   localparam int RowW  = EntW * Ways;

   typedef enum logic [1:0] {
      POL_FIFO = 2'd0,
      POL_LRU  = 2'd1,
      POL_LFU  = 2'd2,
      POL_LFU3 = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ACC   = 2'd1,
      ST_INV   = 2'd2,
      ST_OUT   = 2'd3
   } state_type;

   typedef struct packed {
      logic [TagW-1:0] tag;
      logic [31:0]     ins;
      logic [31:0]     use_st;
      logic [15:0]     cnt;
   } entry_type;
endpackage
`default_nettype wire

// ===== rtl/sact_ram.sv =====
`default_nettype none
module sact_ram #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_tag_replacement.sv =====
// Set-associative cache tag store with FIFO, LRU or LFU replacement.
// Input transactions arrive on req_ (tdata: address, range_size; tuser:
// operation, 0 access, 1 range invalidate). One result transaction per input
// leaves on rsp_ (tdata: hit_total, miss_total; tuser: hit, miss).
// An access reads its set from the tag RAM at the accepting edge, then
// compares, picks a victim and writes the set back in the next cycle. The
// result then moves into the output register from ST_OUT once that register
// is free, and the next transaction can be accepted back in ST_IDLE.
// A range invalidate walks every set in ST_INV, one set per cycle through
// the same RAM port. Its result then moves into the output register from
// ST_OUT, and the next transaction can be accepted back in ST_IDLE.
// One transaction is in work at a time; req_tready is high while the block
// is idle, including while the previous result still waits in the output
// register, so a new access overlaps the wait. If the receiver stalls, the
// finished result holds in the output register and the block stops before
// delivering a second one.
// Reset clears the valid bits (flip-flops), the access clock, the hit and
// miss counters and the policy; tag RAM contents need no clearing since
// the contents of invalid ways never affect a result.
// csr_wr_en with csr_wr_data writes the replacement policy.
`default_nettype none
module set_assoc_cache_tag_replacement
   import sact_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // address, range_size
   input  wire logic         req_tuser,   // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // hit_total, miss_total
   output logic [1:0]        rsp_tuser    // hit, miss
);
   state_type   state_ff, state_in;
   logic [1:0]  pol_ff;
   logic [Ways-1:0] valid_ff [NumSets];
   logic [31:0] clk_ff, hits_ff, miss_ff;
   logic [31:0] addr_ff;
   logic [32:0] hi_ff;
   logic [SetW-1:0] set_ff;
   logic [SetW:0]   walk_ff;
   logic        hit_ff, missb_ff;
   logic        ovalid_ff, ovalid_in;

   logic            ram_we;
   logic [SetW-1:0] ram_raddr;
   logic [RowW-1:0] ram_wdata, ram_rdata;

   entry_type ent [Ways];
   entry_type nent [Ways];
   logic [Ways-1:0] nvalid;
   logic            acc_hit;
   logic [31:0]     clk_nx;
   logic [SetW-1:0] req_set;

   logic accept;
   assign accept   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_set  = SetW'(req_tdata[OffW +: SetW] & SetW'(NumSets-1));

   always_comb begin
      unique case (state_ff)
         ST_INV:  ram_raddr = walk_ff[SetW-1:0];
         default: ram_raddr = req_set;
      endcase
   end

   sact_ram #(.Width(RowW), .Depth(NumSets > 1 ? NumSets : 2)) u_ram (
      .clock(clock), .we(ram_we), .waddr(set_ff), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata));

   assign clk_nx = clk_ff + 32'd1;

   always_comb begin
      logic [WayW-1:0] best, hw, fw;
      logic            smaller, found_inv;
      logic [TagW-1:0] tag;
      logic [32:0] bs, be;
      tag = addr_ff[31 -: TagW];
      smaller = 1'b0; bs = '0; be = '0;
      for (int w = 0; w < Ways; w++) ent[w] = ram_rdata[w*EntW +: EntW];
      acc_hit = 1'b0; hw = '0; found_inv = 1'b0; fw = '0; best = '0;
      for (int w = Ways-1; w >= 0; w--) begin
         if (valid_ff[set_ff][w] && ent[w].tag == tag) begin
            acc_hit = 1'b1; hw = WayW'(w);
         end
         if (!valid_ff[set_ff][w]) begin
            found_inv = 1'b1; fw = WayW'(w);
         end
      end
      for (int w = 1; w < Ways; w++) begin
         unique case (policy_type'(pol_ff))
            POL_FIFO: smaller = ent[w].ins < ent[best].ins;
            POL_LRU:  smaller = ent[w].use_st < ent[best].use_st;
            default:  smaller = ent[w].cnt < ent[best].cnt;
         endcase
         if (smaller) best = WayW'(w);
      end
      for (int w = 0; w < Ways; w++) nent[w] = ent[w];
      nvalid = valid_ff[set_ff];
      if (state_ff == ST_INV) begin
         for (int w = 0; w < Ways; w++) begin
            bs = {1'b0, ent[w].tag, set_ff, OffW'(0)};
            be = bs + 33'(BlockBytes);
            if (valid_ff[set_ff][w] && bs < hi_ff && be > {1'b0, addr_ff})
               nvalid[w] = 1'b0;
         end
      end else if (acc_hit) begin
         nent[hw].use_st = clk_nx;
         if (ent[hw].cnt != 16'hFFFF) nent[hw].cnt = ent[hw].cnt + 16'd1;
      end else begin
         if (found_inv) best = fw;
         nent[best] = '{tag: tag, ins: clk_nx, use_st: clk_nx, cnt: 16'd1};
         nvalid[best] = 1'b1;
      end
      for (int w = 0; w < Ways; w++) ram_wdata[w*EntW +: EntW] = nent[w];
   end

   assign ram_we = (state_ff == ST_ACC);

   // Next state: an access compares in ST_ACC, an invalidate walks all sets
   // in ST_INV, and ST_OUT waits until the output register is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = req_tuser ? ST_INV : ST_ACC;
         ST_ACC:  state_in = ST_OUT;
         ST_INV:  if (walk_ff == (SetW+1)'(NumSets)) state_in = ST_OUT;
         ST_OUT:  if (!ovalid_ff || rsp_tready) state_in = ST_IDLE;
      endcase
   end

   // The output register empties when its transaction is taken and refills
   // when a finished result moves in; both may happen at the same edge.
   always_comb begin
      ovalid_in = ovalid_ff;
      if (rsp_tvalid && rsp_tready) ovalid_in = 1'b0;
      if (state_ff == ST_OUT && (!ovalid_ff || rsp_tready)) ovalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pol_ff <= 2'd0; clk_ff <= '0;
         hits_ff <= '0; miss_ff <= '0; ovalid_ff <= 1'b0;
         for (int s = 0; s < NumSets; s++) valid_ff[s] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) pol_ff <= csr_wr_data;
         ovalid_ff <= ovalid_in;
         if (state_ff == ST_ACC) begin
            clk_ff <= clk_nx;
            valid_ff[set_ff] <= nvalid;
            if (acc_hit) hits_ff <= hits_ff + 32'd1;
            else         miss_ff <= miss_ff + 32'd1;
         end
         if (state_ff == ST_INV && walk_ff != '0) valid_ff[set_ff] <= nvalid;
      end
   end

   // Payload registers. During the walk set_ff registers the read address, so
   // it names the row that the RAM returns.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_tdata[31:0];
         hi_ff   <= {1'b0, req_tdata[31:0]} + {1'b0, req_tdata[63:32]};
         set_ff  <= req_set;
         walk_ff <= '0;
         hit_ff  <= 1'b0; missb_ff <= 1'b0;
      end
      if (state_ff == ST_INV) begin
         walk_ff <= walk_ff + 1'b1;
         set_ff  <= walk_ff[SetW-1:0];
      end
      if (state_ff == ST_ACC) begin
         hit_ff <= acc_hit; missb_ff <= !acc_hit;
      end
      if (state_ff == ST_OUT && (!ovalid_ff || rsp_tready)) begin
         rsp_tdata <= {miss_ff, hits_ff};
         rsp_tuser <= {missb_ff, hit_ff};
      end
   end

   assign rsp_tvalid = ovalid_ff;
endmodule
`default_nettype wire

// ===== rtl/sact_checker.sv =====
`default_nettype none
`include "set_assoc_cache_tag_replacement_assert.svh"
module sact_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [1:0]  rsp_tuser
);
   `SACT_ASSERT_IMPL(a_onehot_kind, clock, reset, rsp_tvalid, $countones(rsp_tuser) <= 1, "hit and miss both set")
   `SACT_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tuser), "stalled result changed")
   `SACT_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "accepted two items back to back")
endmodule
bind set_assoc_cache_tag_replacement sact_checker u_chk (.*);
`default_nettype wire

// ===== sim/set_assoc_cache_tag_replacement_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module set_assoc_cache_tag_replacement_tb;
   import sact_pkg::*;

   localparam int LINES = NumSets * Ways;

   // Opcodes carried on req_tuser.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_INVAL  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = POL_FIFO;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // address, range_size
   logic        req_tuser = OP_ACCESS;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;   // hit_total, miss_total
   logic [1:0]  rsp_tuser;   // hit, miss

   set_assoc_cache_tag_replacement u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // One lookup result as the block reports it.
   typedef struct packed {
      logic        hit;
      logic        miss;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } lookup_type;

   // A directed row; the expected result is typed in only where has_exp is set.
   typedef struct {
      logic    op;
      logic [31:0] addr;
      logic [31:0] size;
      bit      has_exp;
      lookup_type exp;
   } row_type;

   // Shadow copy of the tag store that the predictor keeps up to date.
   logic            shadow_valid [LINES];
   logic [TagW-1:0] shadow_tag   [LINES];
   logic [31:0]     shadow_ins   [LINES];
   logic [31:0]     shadow_use   [LINES];
   logic [15:0]     shadow_cnt   [LINES];
   logic [31:0]     shadow_clock;
   logic [31:0]     shadow_hits;
   logic [31:0]     shadow_misses;
   policy_type      shadow_policy;

   lookup_type pending_lookups[$];
   int      errors = 0;
   bit      calm_sender = 1'b0;
   bit      calm_receiver = 1'b0;
   bit      hold_request = 1'b0;

   // Predicts the result of one accepted transaction and updates the shadow store.
   function automatic lookup_type predict_lookup(logic op, logic [31:0] addr,
                                                 logic [31:0] size);
      lookup_type      r;
      logic [TagW-1:0] tg;
      int              base;
      int              slot;
      int              best;
      bit              smaller;
      logic [63:0]     lo;
      logic [63:0]     hi;
      logic [63:0]     bstart;
      r = '0;
      if (op == OP_ACCESS) begin
         tg = addr[31:OffW+SetB];
         base = int'(addr[OffW+SetB-1:OffW]) * Ways;
         shadow_clock = shadow_clock + 32'd1;
         slot = -1;
         for (int w = 0; w < Ways; w++) begin
            if (slot < 0 && shadow_valid[base+w] && shadow_tag[base+w] == tg) slot = base + w;
         end
         if (slot >= 0) begin
            shadow_use[slot] = shadow_clock;
            if (shadow_cnt[slot] != 16'hFFFF) shadow_cnt[slot] = shadow_cnt[slot] + 16'd1;
            shadow_hits = shadow_hits + 32'd1;
            r.hit = 1'b1;
         end else begin
            shadow_misses = shadow_misses + 32'd1;
            r.miss = 1'b1;
            for (int w = Ways - 1; w >= 0; w--) begin
               if (!shadow_valid[base+w]) slot = base + w;
            end
            if (slot < 0) begin
               // Every way is valid: the policy picks the victim, lowest way on a tie.
               best = base;
               for (int w = 1; w < Ways; w++) begin
                  case (shadow_policy)
                     POL_FIFO: smaller = shadow_ins[base+w] < shadow_ins[best];
                     POL_LRU:  smaller = shadow_use[base+w] < shadow_use[best];
                     default:  smaller = shadow_cnt[base+w] < shadow_cnt[best];
                  endcase
                  if (smaller) best = base + w;
               end
               slot = best;
            end
            shadow_valid[slot] = 1'b1;
            shadow_tag[slot] = tg;
            shadow_ins[slot] = shadow_clock;
            shadow_use[slot] = shadow_clock;
            shadow_cnt[slot] = 16'd1;
         end
      end else begin
         // The range end is a 33-bit sum, so a range may run past the top of memory.
         lo = {32'd0, addr};
         hi = lo + {32'd0, size};
         for (int s = 0; s < LINES; s++) begin
            bstart = (64'(shadow_tag[s]) * NumSets + 64'(s / Ways)) * BlockBytes;
            if (shadow_valid[s] && bstart < hi && bstart + BlockBytes > lo)
               shadow_valid[s] = 1'b0;
         end
      end
      r.hit_total = shadow_hits;
      r.miss_total = shadow_misses;
      return r;
   endfunction

   // Offers one transaction after a random gap and waits until it is taken.
   task automatic send_request(logic op, logic [31:0] addr, logic [31:0] size,
                               output lookup_type predicted);
      int gap;
      gap = calm_sender ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {size, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_lookup(op, addr, size);
      pending_lookups.push_back(predicted);
   endtask

   // Waits until every result is back and the block has had time to go idle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (NumSets + 8) @(posedge clock);
   endtask

   task automatic write_policy(policy_type pol);
      csr_wr_en <= 1'b1;
      csr_wr_data <= pol;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_policy = pol;
   endtask

   // Random address biased toward a few tags in a few sets so that hits,
   // fills and evictions all occur; one in ten is a fully random address.
   function automatic logic [31:0] pick_address();
      logic [TagW-1:0] tg;
      logic [SetB-1:0] st;
      case ($urandom_range(0, 5))
         0: tg = '1;
         1: tg = TagW'($urandom_range(0, 63));
         default: tg = TagW'($urandom_range(0, 5));
      endcase
      st = ($urandom_range(0, 3) == 0) ? SetB'($urandom) : SetB'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) return $urandom;
      return {tg, st, OffW'($urandom)};
   endfunction

   // Receiver: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_request) stall = 600;
         else stall = calm_receiver ? 0 : $urandom_range(0, 17);
         hold_request = 1'b0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Scoreboard: each delivered result against the oldest prediction.
   always @(posedge clock) begin
      lookup_type got;
      lookup_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tuser[1], rsp_tdata[31:0], rsp_tdata[63:32]};
         if (pending_lookups.size() == 0) begin
            $display("%0t: unexpected result hit=%0b miss=%0b totals=%0d/%0d", $time,
                     got.hit, got.miss, got.hit_total, got.miss_total);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
               errors++;
            end
            if (got.miss !== want.miss) begin
               $display("%0t: miss expected %0b actual %0b", $time, want.miss, got.miss);
               errors++;
            end
            if (got.hit_total !== want.hit_total) begin
               $display("%0t: hit_total expected %0d actual %0d", $time,
                        want.hit_total, got.hit_total);
               errors++;
            end
            if (got.miss_total !== want.miss_total) begin
               $display("%0t: miss_total expected %0d actual %0d", $time,
                        want.miss_total, got.miss_total);
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, then random phases under each policy.
   initial begin
      row_type     rows[15];
      lookup_type  predicted;
      policy_type  phases[6];
      logic        op;
      logic [31:0] size;
      for (int i = 0; i < LINES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_tag[i] = '0;
         shadow_ins[i] = '0;
         shadow_use[i] = '0;
         shadow_cnt[i] = '0;
      end
      shadow_clock = '0;
      shadow_hits = '0;
      shadow_misses = '0;
      shadow_policy = POL_FIFO;

      // Totals right after reset, the extremes of address and range, an empty
      // range, and a range whose end carries past 32 bits.
      rows[0]  = '{OP_ACCESS, 32'h0000_0000, 32'h0, 1, '{1'b0, 1'b1, 32'd0, 32'd1}};
      rows[1]  = '{OP_ACCESS, 32'h0000_003F, 32'hFFFF_FFFF, 1, '{1'b1, 1'b0, 32'd1, 32'd1}};
      rows[2]  = '{OP_ACCESS, 32'hFFFF_FFFF, 32'h0, 1, '{1'b0, 1'b1, 32'd1, 32'd2}};
      rows[3]  = '{OP_INVAL,  32'h0000_0000, 32'h0, 1, '{1'b0, 1'b0, 32'd1, 32'd2}};
      rows[4]  = '{OP_INVAL,  32'hFFFF_FFC0, 32'hFFFF_FFFF, 1, '{1'b0, 1'b0, 32'd1, 32'd2}};
      rows[5]  = '{OP_ACCESS, 32'hFFFF_FFC0, 32'h0, 1, '{1'b0, 1'b1, 32'd1, 32'd3}};
      // Fill set zero and force an eviction, then clear partial and straddling ranges.
      rows[6]  = '{OP_ACCESS, 32'h0000_1000, 32'h0, 0, '0};
      rows[7]  = '{OP_ACCESS, 32'h0000_2000, 32'h0, 0, '0};
      rows[8]  = '{OP_ACCESS, 32'h0000_3000, 32'h0, 0, '0};
      rows[9]  = '{OP_ACCESS, 32'h0000_4000, 32'h0, 0, '0};
      rows[10] = '{OP_ACCESS, 32'h0000_0010, 32'h0, 0, '0};
      rows[11] = '{OP_INVAL,  32'h0000_1000, 32'h1, 0, '0};
      rows[12] = '{OP_ACCESS, 32'h0000_1020, 32'h0, 0, '0};
      rows[13] = '{OP_INVAL,  32'h0000_3FFF, 32'h2, 0, '0};
      rows[14] = '{OP_ACCESS, 32'h0000_4004, 32'h0, 0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_request(rows[i].op, rows[i].addr, rows[i].size, predicted);
         if (rows[i].has_exp && predicted !== rows[i].exp) begin
            $display("%0t: row %0d expected %h actual prediction %h", $time, i,
                     rows[i].exp, predicted);
            errors++;
         end
      end
      drain_results();

      // Policy code three is checked too; it must behave as fewest uses.
      phases = '{POL_LRU, POL_LFU, POL_FIFO, POL_LFU3, POL_LRU, POL_LFU};
      foreach (phases[p]) begin
         write_policy(phases[p]);
         for (int n = 0; n < 180; n++) begin
            if (n % 60 == 0) begin
               calm_sender = ($urandom_range(0, 2) == 0);
               calm_receiver = ($urandom_range(0, 2) == 0);
            end
            // Long receiver hold-off while the sender keeps offering back to back.
            if (p == 1 && n == 20) begin
               hold_request = 1'b1;
               calm_sender = 1'b1;
            end
            op = ($urandom_range(0, 11) == 0) ? OP_INVAL : OP_ACCESS;
            case ($urandom_range(0, 3))
               0: size = $urandom;
               1: size = 32'($urandom_range(0, 1)) * BlockBytes;
               default: size = $urandom_range(0, 700);
            endcase
            send_request(op, pick_address(), size, predicted);
         end
         drain_results();
      end

      calm_receiver = 1'b1;
      drain_results();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/sact_pkg.sv
rtl/sact_ram.sv
rtl/set_assoc_cache_tag_replacement.sv
rtl/sact_checker.sv
sim/set_assoc_cache_tag_replacement_tb.sv
